// ===== hdl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the windowed debounce core
// Register indexes, reset values and the window control bundle that the
// top level hands to every sensor lane.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int CFG_WIDTH = 8;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int WINDOW_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH  = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_THRESHOLD = 1'd1;

  localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET  = 8'd25;
  localparam logic [CFG_WIDTH-1:0] HIGH_THRESHOLD_RESET = 8'd20;

  // take: a sample transaction is accepted this cycle
  // gather: window still open, so the sample is counted; else evaluate
  typedef struct packed {
    logic take;
    logic gather;
  } win_ctrl_t;

endpackage

// ===== hdl/wsd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_lane: one sensor's high-sample counter
// Saturating count of high samples in the current window, cleared on
// evaluation, with the threshold compare for the qualified level.
// ----------------------------------------------------------------------------
module wsd_lane #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wsd_pkg::win_ctrl_t             ctrl,
  input  logic                           sample,
  input  logic [wsd_pkg::CFG_WIDTH-1:0]  high_threshold,
  output logic                           level
);

  localparam int CMP_WIDTH =
    (COUNT_WIDTH > wsd_pkg::CFG_WIDTH) ? COUNT_WIDTH : wsd_pkg::CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ctrl.take) begin
      if (!ctrl.gather) begin
        count_next = '0;
      end else if (sample && (count != COUNT_MAX)) begin
        count_next = count + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // level reflects the count gathered so far; used on the evaluating tick
  assign level = CMP_WIDTH'(count) >= CMP_WIDTH'(high_threshold);

endmodule

// ===== hdl/windowed_sample_count_debounce_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sample_count_debounce_core: windowed debounce of sensor lines
// Counts high samples per sensor over a configurable window, then qualifies
// each sensor against a threshold and starts a new window.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall, sample_bits): one transaction per
//    tick, bit i is the raw level of sensor i.
//  - Output channel (out_valid / out_stall, sensor_state, updated): exactly
//    one transaction per input transaction, in order.
//  - While the window count is below window_length a sample is counted; the
//    next transaction ignores its sample, evaluates all sensors against
//    high_threshold, reports updated = 1 and clears the counters.
//  - The result register holds the outcome the cycle after acceptance.
//    Throughput is one transaction per cycle unless the receiver stalls,
//    set by the single result register between the lanes and the output.
//  - When the receiver stalls a held result, in_stall rises in the same
//    cycle; a result taken frees the register for a new sample at once.
//  - Reset (rst, synchronous) clears counters, window count, qualified
//    levels and out_valid, and restores window_length = 25 and
//    high_threshold = 20.
//  - Configuration (cfg_write, cfg_index, cfg_data) is taken on any cycle
//    with cfg_write high; write it only while the core is idle.
// ----------------------------------------------------------------------------
module windowed_sample_count_debounce_core #(
  parameter int NUM_SENSORS = 5,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [NUM_SENSORS-1:0]               sample_bits,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [NUM_SENSORS-1:0]               sensor_state,
  output logic                                 updated,
  // configuration
  input  logic                                 cfg_write,
  input  logic [wsd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wsd_pkg::CFG_WIDTH-1:0]        cfg_data
);

  // configuration registers
  logic [wsd_pkg::CFG_WIDTH-1:0] window_length;
  logic [wsd_pkg::CFG_WIDTH-1:0] high_threshold;

  // window state
  logic [wsd_pkg::WINDOW_WIDTH-1:0] window_count;
  logic [wsd_pkg::WINDOW_WIDTH-1:0] window_count_next;
  logic [NUM_SENSORS-1:0]           qualified_levels;
  logic [NUM_SENSORS-1:0]           qualified_levels_next;
  logic [NUM_SENSORS-1:0]           lane_levels;

  wsd_pkg::win_ctrl_t ctrl;
  logic               take;

  // the result register is free when empty or being drained this cycle
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  assign ctrl.take   = take;
  assign ctrl.gather = window_count < window_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= wsd_pkg::WINDOW_LENGTH_RESET;
      high_threshold <= wsd_pkg::HIGH_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        wsd_pkg::REG_WINDOW_LENGTH:  window_length  <= cfg_data;
        wsd_pkg::REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // one counter lane per sensor
  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    wsd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .sample         (sample_bits[i]),
      .high_threshold (high_threshold),
      .level          (lane_levels[i])
    );
  end

  always_comb begin
    window_count_next     = window_count;
    qualified_levels_next = qualified_levels;
    if (take) begin
      if (ctrl.gather) begin
        window_count_next = window_count + wsd_pkg::WINDOW_WIDTH'(1);
      end else begin
        // evaluating tick: sample ignored, window restarts
        window_count_next     = '0;
        qualified_levels_next = lane_levels;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count     <= '0;
      qualified_levels <= '0;
    end else begin
      window_count     <= window_count_next;
      qualified_levels <= qualified_levels_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sensor_state <= qualified_levels_next;
      updated      <= !ctrl.gather;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for windowed_sample_count_debounce_core
// Drives sample transactions with random gaps, stalls the result channel at
// random and checks every result transaction against a cycle-free model of
// the windowed debounce, kept in step by watching both handshakes and the
// configuration writes.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_SENSORS = 5;
  localparam int COUNT_WIDTH = 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  // the result register is loaded the cycle after acceptance; settle with margin
  localparam int SETTLE_CYCLES = 4;
  // random phases on top of roughly 320 directed transactions
  localparam int RANDOM_SAMPLES = 900;

  typedef logic [NUM_SENSORS-1:0] sensor_vec_t;

  typedef struct packed {
    sensor_vec_t sensor_state;
    logic        updated;
  } debounce_out_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  sensor_vec_t                         sample_bits;
  logic                                out_valid;
  logic                                out_stall;
  sensor_vec_t                         sensor_state;
  logic                                updated;
  logic                                cfg_write;
  logic [wsd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [wsd_pkg::CFG_WIDTH-1:0]       cfg_data;

  // Debounce model state: per-lane high counts, samples gathered so far in
  // the current window, last qualified levels and its own register copies.
  logic [COUNT_WIDTH-1:0]           lane_high_count [NUM_SENSORS];
  logic [wsd_pkg::WINDOW_WIDTH-1:0] window_fill;
  sensor_vec_t                      qualified_q;
  logic [wsd_pkg::CFG_WIDTH-1:0]    window_len_q;
  logic [wsd_pkg::CFG_WIDTH-1:0]    threshold_q;

  debounce_out_t pending_results[$];
  int            fail_count = 0;

  // Idle shaping: each side draws its wait per transaction from 0..max.
  // A max of 0 gives back-to-back stretches.
  int in_gap_max  = 9;
  int out_gap_max = 9;
  // Chance, in percent, that sensor i reads high in a random sample
  int high_pct [NUM_SENSORS];

  windowed_sample_count_debounce_core #(
    .NUM_SENSORS(NUM_SENSORS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_bits (sample_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sensor_state(sensor_state),
    .updated     (updated),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard: ends a hung run with an error.
  initial begin
    #2_000_000;
    $display("[windowed_sample_count_debounce_core] ERROR");
    $finish;
  end

  // One tick of the debounce. While the window is still open the sample is
  // counted (counts saturate); otherwise the sample is dropped, every lane
  // is compared with the threshold and the window restarts.
  function automatic debounce_out_t debounce_tick(input sensor_vec_t sample);
    debounce_out_t res;
    res.updated = 1'b0;
    if (window_fill < window_len_q) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (sample[i] && lane_high_count[i] != COUNT_MAX)
          lane_high_count[i] = lane_high_count[i] + 1'b1;
      end
      window_fill = window_fill + 1'b1;
    end else begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        qualified_q[i]     = (lane_high_count[i] >= threshold_q);
        lane_high_count[i] = '0;
      end
      window_fill = '0;
      res.updated = 1'b1;
    end
    res.sensor_state = qualified_q;
    return res;
  endfunction

  function automatic sensor_vec_t draw_sample();
    sensor_vec_t s;
    for (int i = 0; i < NUM_SENSORS; i++)
      s[i] = ($urandom_range(0, 99) < high_pct[i]);
    return s;
  endfunction

  // Single observer of both channels. The model advances on every accepted
  // sample transaction before results of the same edge are checked, so the
  // outcome does not hinge on process ordering within a time step.
  always @(posedge clk) begin
    debounce_out_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        lane_high_count[i] = '0;
      window_fill  = '0;
      qualified_q  = '0;
      window_len_q = wsd_pkg::WINDOW_LENGTH_RESET;
      threshold_q  = wsd_pkg::HIGH_THRESHOLD_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == wsd_pkg::REG_WINDOW_LENGTH)
          window_len_q = cfg_data;
        else if (cfg_index == wsd_pkg::REG_HIGH_THRESHOLD)
          threshold_q = cfg_data;
      end
      if (in_valid && !in_stall)
        pending_results.push_back(debounce_tick(sample_bits));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with none pending: sensor_state=%0h updated=%0b",
                 sensor_state, updated);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (sensor_state !== want.sensor_state) begin
            $error("sensor_state: expected %0h, got %0h", want.sensor_state, sensor_state);
            fail_count++;
          end
          if (updated !== want.updated) begin
            $error("updated: expected %0b, got %0b", want.updated, updated);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: stall for a drawn number of cycles, then take one result.
  initial begin
    int gap;
    out_stall <= 1'b0;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Sender: optional gap, then hold the sample until it is taken. Valid is
  // left high on return so back-to-back transactions need no second edit.
  task automatic send_sample(input sensor_vec_t sample);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_bits <= sample;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written on consecutive edges; window state is kept,
  // so a shorter length can close an open window on the next sample.
  task automatic configure(input logic [wsd_pkg::CFG_WIDTH-1:0] win_len,
                           input logic [wsd_pkg::CFG_WIDTH-1:0] threshold);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= wsd_pkg::REG_WINDOW_LENGTH;
    cfg_data  <= win_len;
    @(posedge clk);
    cfg_index <= wsd_pkg::REG_HIGH_THRESHOLD;
    cfg_data  <= threshold;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values: window of 25, threshold 20. Lanes are spread from always
  // high down to rarely high so both outcomes show up over two windows.
  task automatic test_reset_defaults();
    high_pct = '{100, 90, 80, 50, 5};
    repeat (52) send_sample(draw_sample());
  endtask

  // Zero-length window: every tick evaluates with empty counts, so the
  // levels are all high only for a zero threshold.
  task automatic test_zero_window();
    configure(8'd0, 8'd0);
    send_sample(5'h00);
    send_sample(5'h1F);
    configure(8'd0, 8'd1);
    send_sample(5'h1F);
  endtask

  // One-sample window with threshold 1: the levels follow alternate samples.
  task automatic test_one_sample_window();
    configure(8'd1, 8'd1);
    send_sample(5'h15);
    send_sample(5'h00);
    send_sample(5'h0A);
    send_sample(5'h1F);
  endtask

  // Length cut below the fill of an open window: the next sample evaluates.
  task automatic test_window_shrink();
    configure(8'd6, 8'd2);
    send_sample(5'h1F);
    send_sample(5'h03);
    send_sample(5'h01);
    configure(8'd2, 8'd2);
    send_sample(5'h1F);
    send_sample(5'h1F);
    send_sample(5'h1F);
    send_sample(5'h00);
  endtask

  // Longest window and highest threshold: lanes reach full count, lane 0
  // misses by one sample.
  task automatic test_counter_saturation();
    configure(8'd255, 8'd255);
    send_sample(5'h1E);
    repeat (254) send_sample(5'h1F);
    send_sample(5'h00);
  endtask

  // Random phases: mostly short windows with thresholds drawn up to one above
  // the window length, a few zero, mid-size and reset-size windows, random per-lane
  // duty and a mix of idle and back-to-back stretches on both sides.
  task automatic test_random_windows();
    int remaining;
    int win_len;
    int threshold;
    int phase_len;
    int pick;
    remaining = RANDOM_SAMPLES;
    while (remaining > 0) begin
      pick = $urandom_range(0, 15);
      if (pick == 0)
        win_len = 0;
      else if (pick < 11)
        win_len = $urandom_range(1, 8);
      else if (pick < 15)
        win_len = $urandom_range(9, 40);
      else
        win_len = int'(wsd_pkg::WINDOW_LENGTH_RESET);
      pick = $urandom_range(0, 9);
      if (pick == 0)
        threshold = 0;
      else if (pick == 1)
        threshold = 255;
      else
        threshold = $urandom_range(0, win_len + 1);
      for (int i = 0; i < NUM_SENSORS; i++)
        high_pct[i] = $urandom_range(0, 100);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 9;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      configure(win_len[wsd_pkg::CFG_WIDTH-1:0], threshold[wsd_pkg::CFG_WIDTH-1:0]);
      phase_len = $urandom_range(win_len + 1, 3 * (win_len + 1) + 10);
      repeat (phase_len) send_sample(draw_sample());
      remaining -= phase_len;
    end
    in_gap_max  = 9;
    out_gap_max = 9;
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    sample_bits <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= wsd_pkg::REG_WINDOW_LENGTH;
    cfg_data    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_window();
    test_one_sample_window();
    test_window_shrink();
    test_counter_saturation();
    test_random_windows();
    wait_idle();

    if (fail_count == 0)
      $display("[windowed_sample_count_debounce_core] OK");
    else
      $display("[windowed_sample_count_debounce_core] ERROR");
    $finish;
  end

endmodule
